@@ rtl/gds_pkg.sv @@
// Shared types, constants and calendar functions for the Gregorian date stepper.
package gds_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1900;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd3000;
  localparam logic [YEAR_W-1:0] YEAR_DEF = 12'd2023;
  localparam logic [DAY_W-1:0]  DAY_DEF  = 5'd1;
  localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
  localparam logic [MON_W-1:0]  MON_APR  = 4'd4;
  localparam logic [MON_W-1:0]  MON_JUN  = 4'd6;
  localparam logic [MON_W-1:0]  MON_SEP  = 4'd9;
  localparam logic [MON_W-1:0]  MON_NOV  = 4'd11;
  localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;

  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LOAD = 2'd1,
    STAT_BOUND    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;     // take the load request fields
    logic start;    // take the move request count
    logic step;     // move the date one day
    logic bound;    // stop stepping at a year bound
    logic capture;  // copy the date and status into the output register
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic blocked;
  } stat_t;

  // Exact for years 1900 to 3000; other years never reach a month length
  // that matters, since such a load is rejected on its year alone.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic century_common;
    century_common = (y == 12'd1900) || (y == 12'd2100) || (y == 12'd2200) ||
                     (y == 12'd2300) || (y == 12'd2500) || (y == 12'd2600) ||
                     (y == 12'd2700) || (y == 12'd2900) || (y == 12'd3000);
    return (y[1:0] == 2'd0) && !century_common;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] d;
    if (m == MON_FEB) begin
      d = is_leap(y) ? 5'd29 : 5'd28;
    end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
      d = 5'd30;
    end else begin
      d = 5'd31;
    end
    return d;
  endfunction

endpackage

@@ rtl/gregorian_date_stepper_unit.sv @@
// Gregorian date stepper: holds a calendar date, loads it or moves it one day per cycle.
//
// Usage:
//   The request channel (in_valid/in_ready) carries a load or a move. A load
//   (in_req_type = 1) checks the date and falls back to 1/1/2023 with status 1
//   when it is invalid. A move (in_req_type = 0) steps the date by the signed
//   in_day_count, one day per clock, its size capped at MAX_STEP; stepping
//   stops with status 2 at 31/12/3000 forward or 1/1/1900 backward.
//   Every request yields one result on the out_ channel (out_valid/out_ready).
// Timing:
//   A load goes from idle to the finish state, which registers its result. A move
//   first passes the step state, where the day counter loop steps the date.
//   The controller is idle again once it registers a result, so the next request
//   is taken while that result is presented. The result sits in an output
//   register, so the next request is taken and worked on while an earlier result
//   still waits for its transfer.
// Reset:
//   Synchronous, active low; the date returns to 1/1/2023 and no result is
//   pending. A stalled receiver holds the result stable and, once the next
//   result is ready, holds the block in its finish state.
module gregorian_date_stepper_unit #(
  parameter int MAX_STEP = 1023
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic signed [gds_pkg::CNT_W-1:0]  in_day_count,
  input  logic [gds_pkg::DAY_W-1:0]         in_load_day,
  input  logic [gds_pkg::MON_W-1:0]         in_load_month,
  input  logic [gds_pkg::YEAR_W-1:0]        in_load_year,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gds_pkg::DAY_W-1:0]         out_cur_day,
  output logic [gds_pkg::MON_W-1:0]         out_cur_month,
  output logic [gds_pkg::YEAR_W-1:0]        out_cur_year,
  output logic [gds_pkg::STAT_W-1:0]        out_status
);

  gds_pkg::cmd_t  cmd;
  gds_pkg::stat_t dp_stat;

  gds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (dp_stat),
    .cmd         (cmd)
  );

  gds_datapath #(
    .MAX_STEP (MAX_STEP)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (dp_stat),
    .in_day_count  (in_day_count),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .out_cur_day   (out_cur_day),
    .out_cur_month (out_cur_month),
    .out_cur_year  (out_cur_year),
    .out_status    (out_status)
  );

`ifndef SYNTHESIS
  // A day is only stepped while days remain and no year bound blocks it.
  a_step_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!dp_stat.cnt_zero && !dp_stat.blocked))
    else $error("day step issued with no days left or at a year bound");

  // Capturing a result always presents it on the next cycle.
  a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid)
    else $error("captured result not presented");

  // The day counter is empty between requests, so a load leaves it empty.
  a_load_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == gds_pkg::REQ_LOAD)) |=> dp_stat.cnt_zero)
    else $error("day counter not empty after a load transfer");

  // Only the defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == gds_pkg::STAT_OK) ||
                   (out_status == gds_pkg::STAT_BAD_LOAD) ||
                   (out_status == gds_pkg::STAT_BOUND)))
    else $error("undefined status code on the result channel");
`endif

endmodule

@@ rtl/gds_ctrl.sv @@
// Controller state machine: request handshake, day stepping sequence, result handshake.
module gds_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gds_pkg::stat_t stat,
  output gds_pkg::cmd_t  cmd
);

  gds_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == gds_pkg::REQ_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = gds_pkg::ST_FIN;
          end else begin
            cmd.start = 1'b1;
            state_nxt = gds_pkg::ST_STEP;
          end
        end
      end
      gds_pkg::ST_STEP: begin
        if (stat.cnt_zero) begin
          state_nxt = gds_pkg::ST_FIN;
        end else if (stat.blocked) begin
          cmd.bound = 1'b1;
          state_nxt = gds_pkg::ST_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      gds_pkg::ST_FIN: begin
        // The result register frees up in the same cycle its transfer completes.
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = gds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gds_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/gds_datapath.sv @@
// Datapath: date registers, day counter, load check, one-day step logic and result register.
module gds_datapath #(
  parameter int MAX_STEP = 1023
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gds_pkg::cmd_t                 cmd,
  output gds_pkg::stat_t                stat,
  input  logic signed [gds_pkg::CNT_W-1:0] in_day_count,
  input  logic [gds_pkg::DAY_W-1:0]     in_load_day,
  input  logic [gds_pkg::MON_W-1:0]     in_load_month,
  input  logic [gds_pkg::YEAR_W-1:0]    in_load_year,
  output logic [gds_pkg::DAY_W-1:0]     out_cur_day,
  output logic [gds_pkg::MON_W-1:0]     out_cur_month,
  output logic [gds_pkg::YEAR_W-1:0]    out_cur_year,
  output logic [gds_pkg::STAT_W-1:0]    out_status
);

  localparam int CW = gds_pkg::CNT_W;
  // The largest magnitude an 11-bit count can carry is 1024.
  localparam logic [CW-1:0] SAT_CNT = (MAX_STEP > 1024) ? CW'(1024) : CW'(MAX_STEP);

  logic [gds_pkg::DAY_W-1:0]  day_r, day_nxt;
  logic [gds_pkg::MON_W-1:0]  month_r, month_nxt;
  logic [gds_pkg::YEAR_W-1:0] year_r, year_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       back_r, back_nxt;
  gds_pkg::status_t           stat_r, stat_nxt;

  logic [gds_pkg::DAY_W-1:0]  out_day_r;
  logic [gds_pkg::MON_W-1:0]  out_month_r;
  logic [gds_pkg::YEAR_W-1:0] out_year_r;
  logic [gds_pkg::STAT_W-1:0] out_status_r;

  logic [CW-1:0]              raw_cnt, mag, mag_sat;
  logic                       load_ok;
  logic [gds_pkg::DAY_W-1:0]  cur_len, prev_len;
  logic [gds_pkg::MON_W-1:0]  prev_month;
  logic [gds_pkg::YEAR_W-1:0] prev_year;
  logic                       end_fwd, end_back;

  always_comb begin
    raw_cnt = $unsigned(in_day_count);
    mag     = raw_cnt[CW-1] ? (~raw_cnt + CW'(1)) : raw_cnt;
    mag_sat = (mag > SAT_CNT) ? SAT_CNT : mag;

    load_ok = (in_load_month >= gds_pkg::MON_JAN) && (in_load_month <= gds_pkg::MON_DEC) &&
              (in_load_year >= gds_pkg::YEAR_MIN) && (in_load_year <= gds_pkg::YEAR_MAX) &&
              (in_load_day != '0) &&
              (in_load_day <= gds_pkg::month_days(in_load_month, in_load_year));

    cur_len = gds_pkg::month_days(month_r, year_r);
    if (month_r <= gds_pkg::MON_JAN) begin
      prev_month = gds_pkg::MON_DEC;
      prev_year  = year_r - gds_pkg::YEAR_W'(1);
    end else begin
      prev_month = month_r - gds_pkg::MON_W'(1);
      prev_year  = year_r;
    end
    prev_len = gds_pkg::month_days(prev_month, prev_year);

    end_fwd  = (day_r >= cur_len) && (month_r >= gds_pkg::MON_DEC) &&
               (year_r >= gds_pkg::YEAR_MAX);
    end_back = (day_r <= gds_pkg::DAY_DEF) && (month_r <= gds_pkg::MON_JAN) &&
               (year_r <= gds_pkg::YEAR_MIN);
  end

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.blocked  = back_r ? end_back : end_fwd;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    cnt_nxt   = cnt_r;
    back_nxt  = back_r;
    stat_nxt  = stat_r;
    if (cmd.load) begin
      if (load_ok) begin
        day_nxt   = in_load_day;
        month_nxt = in_load_month;
        year_nxt  = in_load_year;
        stat_nxt  = gds_pkg::STAT_OK;
      end else begin
        day_nxt   = gds_pkg::DAY_DEF;
        month_nxt = gds_pkg::MON_JAN;
        year_nxt  = gds_pkg::YEAR_DEF;
        stat_nxt  = gds_pkg::STAT_BAD_LOAD;
      end
    end else if (cmd.start) begin
      cnt_nxt  = mag_sat;
      back_nxt = raw_cnt[CW-1];
      stat_nxt = gds_pkg::STAT_OK;
    end else if (cmd.bound) begin
      cnt_nxt  = '0;
      stat_nxt = gds_pkg::STAT_BOUND;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - CW'(1);
      if (back_r) begin
        if (day_r <= gds_pkg::DAY_DEF) begin
          day_nxt   = prev_len;
          month_nxt = prev_month;
          year_nxt  = prev_year;
        end else begin
          day_nxt = day_r - gds_pkg::DAY_W'(1);
        end
      end else begin
        if (day_r >= cur_len) begin
          day_nxt = gds_pkg::DAY_DEF;
          if (month_r >= gds_pkg::MON_DEC) begin
            month_nxt = gds_pkg::MON_JAN;
            year_nxt  = year_r + gds_pkg::YEAR_W'(1);
          end else begin
            month_nxt = month_r + gds_pkg::MON_W'(1);
          end
        end else begin
          day_nxt = day_r + gds_pkg::DAY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= gds_pkg::DAY_DEF;
      month_r <= gds_pkg::MON_JAN;
      year_r  <= gds_pkg::YEAR_DEF;
      cnt_r   <= '0;
      back_r  <= 1'b0;
      stat_r  <= gds_pkg::STAT_OK;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      cnt_r   <= cnt_nxt;
      back_r  <= back_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_day_r    <= day_r;
      out_month_r  <= month_r;
      out_year_r   <= year_r;
      out_status_r <= stat_r;
    end
  end

  assign out_cur_day   = out_day_r;
  assign out_cur_month = out_month_r;
  assign out_cur_year  = out_year_r;
  assign out_status    = out_status_r;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the Gregorian date stepper: random loads and day moves.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_STEP = 1023;

  typedef struct {
    logic [gds_pkg::DAY_W-1:0]  day;
    logic [gds_pkg::MON_W-1:0]  month;
    logic [gds_pkg::YEAR_W-1:0] year;
    logic [gds_pkg::STAT_W-1:0] status;
  } date_result_t;

  // Keeps its own copy of the calendar date and lines up the dates that the
  // block must return, one per accepted request.
  class date_tracker;
    logic [gds_pkg::DAY_W-1:0]  day_now;
    logic [gds_pkg::MON_W-1:0]  month_now;
    logic [gds_pkg::YEAR_W-1:0] year_now;
    date_result_t               expected_dates[$];
    int                         failures;

    function new();
      day_now   = 5'd1;
      month_now = gds_pkg::MON_JAN;
      year_now  = gds_pkg::YEAR_DEF;
      failures  = 0;
    endfunction

    function bit leap(input logic [gds_pkg::YEAR_W-1:0] y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function logic [gds_pkg::DAY_W-1:0] month_len(input logic [gds_pkg::MON_W-1:0] m,
                                                  input logic [gds_pkg::YEAR_W-1:0] y);
      if (m == gds_pkg::MON_FEB) begin
        return leap(y) ? 5'd29 : 5'd28;
      end
      if (m == gds_pkg::MON_APR || m == gds_pkg::MON_JUN || m == gds_pkg::MON_SEP ||
          m == gds_pkg::MON_NOV) begin
        return 5'd30;
      end
      return 5'd31;
    endfunction

    // One day forward; returns 0 when the upper year bound blocks it.
    function bit advance();
      if (day_now >= month_len(month_now, year_now)) begin
        if (month_now >= gds_pkg::MON_DEC) begin
          if (year_now >= gds_pkg::YEAR_MAX) return 1'b0;
          year_now  = year_now + 12'd1;
          month_now = gds_pkg::MON_JAN;
        end else begin
          month_now = month_now + 4'd1;
        end
        day_now = 5'd1;
      end else begin
        day_now = day_now + 5'd1;
      end
      return 1'b1;
    endfunction

    // One day back; returns 0 when the lower year bound blocks it.
    function bit retreat();
      if (day_now <= 5'd1) begin
        if (month_now <= gds_pkg::MON_JAN) begin
          if (year_now <= gds_pkg::YEAR_MIN) return 1'b0;
          year_now  = year_now - 12'd1;
          month_now = gds_pkg::MON_DEC;
        end else begin
          month_now = month_now - 4'd1;
        end
        day_now = month_len(month_now, year_now);
      end else begin
        day_now = day_now - 5'd1;
      end
      return 1'b1;
    endfunction

    function void note_request(input logic req, input logic [gds_pkg::CNT_W-1:0] cnt,
                               input logic [gds_pkg::DAY_W-1:0] d,
                               input logic [gds_pkg::MON_W-1:0] m,
                               input logic [gds_pkg::YEAR_W-1:0] y);
      date_result_t              r;
      logic [gds_pkg::CNT_W-1:0] neg;
      int                        mag;
      int                        i;
      bit                        back;
      r.status = gds_pkg::STAT_OK;
      if (req == gds_pkg::REQ_LOAD) begin
        if (m >= gds_pkg::MON_JAN && m <= gds_pkg::MON_DEC && y >= gds_pkg::YEAR_MIN &&
            y <= gds_pkg::YEAR_MAX && d >= 5'd1 && d <= month_len(m, y)) begin
          day_now   = d;
          month_now = m;
          year_now  = y;
        end else begin
          day_now   = gds_pkg::DAY_DEF;
          month_now = gds_pkg::MON_JAN;
          year_now  = gds_pkg::YEAR_DEF;
          r.status  = gds_pkg::STAT_BAD_LOAD;
        end
      end else begin
        back = cnt[gds_pkg::CNT_W-1];
        neg  = ~cnt + 11'd1;
        // The most negative count has no positive twin, so it saturates.
        mag  = back ? int'(neg) : int'(cnt);
        if (mag > MAX_STEP) mag = MAX_STEP;
        for (i = 0; i < mag; i++) begin
          if (!(back ? retreat() : advance())) begin
            r.status = gds_pkg::STAT_BOUND;
            break;
          end
        end
      end
      r.day   = day_now;
      r.month = month_now;
      r.year  = year_now;
      expected_dates.push_back(r);
    endfunction

    function void report(input string what, input date_result_t e, input date_result_t a);
      failures++;
      if (failures <= 10) begin
        $display("%s: expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                 what, e.day, e.month, e.year, e.status, a.day, a.month, a.year, a.status);
      end
    endfunction

    function void check_result(input date_result_t got);
      date_result_t e;
      if (expected_dates.size() == 0) begin
        e = '{default: '0};
        report("result with no request pending", e, got);
        return;
      end
      e = expected_dates.pop_front();
      if (got.day !== e.day || got.month !== e.month || got.year !== e.year ||
          got.status !== e.status) begin
        report("date mismatch", e, got);
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_req_type;
  logic [gds_pkg::CNT_W-1:0]  in_day_count;
  logic [gds_pkg::DAY_W-1:0]  in_load_day;
  logic [gds_pkg::MON_W-1:0]  in_load_month;
  logic [gds_pkg::YEAR_W-1:0] in_load_year;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [gds_pkg::DAY_W-1:0]  out_cur_day;
  logic [gds_pkg::MON_W-1:0]  out_cur_month;
  logic [gds_pkg::YEAR_W-1:0] out_cur_year;
  logic [gds_pkg::STAT_W-1:0] out_status;

  date_tracker tracker;
  int          burst_left;
  logic [1:0]  rx_mode = 2'd0;
  logic [7:0]  rx_cycle = 8'd0;

  gregorian_date_stepper_unit #(
    .MAX_STEP(MAX_STEP)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_day_count (in_day_count),
    .in_load_day  (in_load_day),
    .in_load_month(in_load_month),
    .in_load_year (in_load_year),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cur_day  (out_cur_day),
    .out_cur_month(out_cur_month),
    .out_cur_year (out_cur_year),
    .out_status   (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver switches between steady, random and sparse acceptance.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle[5:0] == 6'd0) begin
      rx_mode <= 2'($urandom_range(0, 3));
    end
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    date_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.note_request(in_req_type, in_day_count, in_load_day, in_load_month,
                             in_load_year);
      end
      if (out_valid && out_ready) begin
        got.day    = out_cur_day;
        got.month  = out_cur_month;
        got.year   = out_cur_year;
        got.status = out_status;
        tracker.check_result(got);
      end
    end
  end

  task automatic send_request(input logic req, input logic [gds_pkg::CNT_W-1:0] cnt,
                              input logic [gds_pkg::DAY_W-1:0] d,
                              input logic [gds_pkg::MON_W-1:0] m,
                              input logic [gds_pkg::YEAR_W-1:0] y);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_day_count  <= cnt;
    in_load_day   <= d;
    in_load_month <= m;
    in_load_year  <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  // Ends a burst with a gap of random length, sometimes none at all.
  task automatic sender_pause();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  initial begin
    logic                       req;
    logic [gds_pkg::CNT_W-1:0]  cnt;
    logic [gds_pkg::DAY_W-1:0]  d;
    logic [gds_pkg::MON_W-1:0]  m;
    logic [gds_pkg::YEAR_W-1:0] y;
    int                         pick;
    tracker       = new();
    burst_left    = 4;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= gds_pkg::REQ_MOVE;
    in_day_count  <= '0;
    in_load_day   <= '0;
    in_load_month <= '0;
    in_load_year  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: leap rules, month and year rollover both ways, bounds,
    // count saturation and rejected loads.
    send_request(gds_pkg::REQ_MOVE, 11'd0, 5'($urandom), 4'($urandom), 12'($urandom));
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd28, gds_pkg::MON_FEB, 12'd2000);
    sender_pause();
    send_request(gds_pkg::REQ_MOVE, 11'd1, 5'd31, 4'd15, 12'd4095);
    send_request(gds_pkg::REQ_MOVE, 11'd1, 5'd0, 4'd0, 12'd0);
    sender_pause();
    send_request(gds_pkg::REQ_MOVE, 11'h7FF, 5'($urandom), 4'($urandom), 12'($urandom));
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd28, gds_pkg::MON_FEB, 12'd1900);
    send_request(gds_pkg::REQ_MOVE, 11'd1, 5'($urandom), 4'($urandom), 12'($urandom));
    sender_pause();
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd1, 4'd3, 12'd2100);
    send_request(gds_pkg::REQ_MOVE, 11'h7FF, 5'($urandom), 4'($urandom), 12'($urandom));
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd1, gds_pkg::MON_JAN, 12'd2024);
    send_request(gds_pkg::REQ_MOVE, 11'h7FF, 5'($urandom), 4'($urandom), 12'($urandom));
    sender_pause();
    send_request(gds_pkg::REQ_LOAD, 11'h7FF, 5'd31, gds_pkg::MON_DEC, gds_pkg::YEAR_MAX);
    send_request(gds_pkg::REQ_MOVE, 11'd1, 5'($urandom), 4'($urandom), 12'($urandom));
    send_request(gds_pkg::REQ_LOAD, 11'h000, 5'd1, gds_pkg::MON_JAN, gds_pkg::YEAR_MIN);
    send_request(gds_pkg::REQ_MOVE, 11'h7FF, 5'($urandom), 4'($urandom), 12'($urandom));
    sender_pause();
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd15, gds_pkg::MON_JUN, 12'd2010);
    send_request(gds_pkg::REQ_MOVE, 11'h400, 5'($urandom), 4'($urandom), 12'($urandom));
    send_request(gds_pkg::REQ_MOVE, 11'd1023, 5'($urandom), 4'($urandom), 12'($urandom));
    sender_pause();
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd0, 4'd0, 12'd0);
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd31, 4'd15, 12'd4095);
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd31, gds_pkg::MON_APR, 12'd2000);
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd29, gds_pkg::MON_FEB, 12'd2023);
    sender_pause();
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd1, gds_pkg::MON_JAN, 12'd3001);
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd31, gds_pkg::MON_DEC, 12'd1899);
    send_request(gds_pkg::REQ_LOAD, 11'($urandom), 5'd31, gds_pkg::MON_JAN,
                 gds_pkg::YEAR_MAX);
    sender_pause();

    // Random part: mostly valid loads and short moves, a few long moves and
    // some loads with arbitrary field values.
    repeat (555) begin
      pick = $urandom_range(0, 99);
      cnt  = 11'($urandom);
      d    = 5'($urandom);
      m    = 4'($urandom);
      y    = 12'($urandom);
      if (pick < 30) begin
        req = gds_pkg::REQ_LOAD;
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 4) == 0) begin
            y = $urandom_range(0, 1) ? gds_pkg::YEAR_MAX : gds_pkg::YEAR_MIN;
            m = 4'($urandom_range(1, 12));
            if ($urandom_range(0, 1)) begin
              m = (y == gds_pkg::YEAR_MAX) ? gds_pkg::MON_DEC : gds_pkg::MON_JAN;
            end
          end else begin
            y = 12'($urandom_range(gds_pkg::YEAR_MIN, gds_pkg::YEAR_MAX));
            m = 4'($urandom_range(1, 12));
          end
          d = ($urandom_range(0, 2) == 0) ? tracker.month_len(m, y) :
              5'($urandom_range(1, tracker.month_len(m, y)));
        end
      end else begin
        req  = gds_pkg::REQ_MOVE;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          cnt = 11'($signed($urandom_range(0, 80)) - 40);
        end else if (pick < 90) begin
          cnt = 11'($signed($urandom_range(0, 600)) - 300);
        end
      end
      send_request(req, cnt, d, m, y);
      sender_pause();
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
